// ===== src/edf_deadline_queue_defines.svh =====
// Assertion macros shared by the deadline queue RTL.
// Depends on nothing; included by the top level.
`ifndef EDF_DEADLINE_QUEUE_DEFINES_SVH
`define EDF_DEADLINE_QUEUE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define EDFQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edfq assertion failed");
// Next-cycle implication checked outside reset.
`define EDFQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edfq assertion failed");
`endif

// ===== src/edfq_pkg.sv =====
// Types and constants of the deadline queue.
// Depends on nothing; imported by every RTL module.
package edfq_pkg;
	localparam int Entries = 1024;
	localparam int IdxW = $clog2(Entries);
	localparam int CntW = $clog2(Entries + 1);

	typedef enum logic [1:0] {
		FUNC_ENQ = 2'd0,
		FUNC_DEQ = 2'd1,
		FUNC_CANCEL = 2'd2,
		FUNC_NOP = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	localparam logic [0:0] REG_CAPACITY = 1'd0;
	localparam logic [0:0] REG_BE_PRIO = 1'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_HEAD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [47:0] now_us;
		logic [31:0] rel_deadline_us;
		logic [61:0] stream_key;
		logic [7:0] prio_level;
		logic [15:0] packet_handle;
		logic [3:0] path_index;
		logic any_path_feasible;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [15:0] out_handle;
		logic [3:0] out_path;
		logic [10:0] cancelled_count;
		logic [10:0] occupancy;
		logic head_valid;
		logic [47:0] head_deadline;
		logic [15:0] head_handle;
		logic [31:0] scheduled_total;
		logic [31:0] dropped_total;
	} out_beat_t;

	typedef struct packed {
		logic [47:0] deadline;
		logic [61:0] stream;
		logic [7:0] prio;
		logic [15:0] handle;
		logic [3:0] path;
	} slot_t;
endpackage

// ===== src/edf_deadline_queue.sv =====
// Earliest-deadline-first queue. Enqueue, dequeue and cancel walk the stored entries
// once through a slot memory with one read and one write port, then read the head slot;
// rejected, empty and unused-code beats skip the walk and go straight to the head read.
// One beat at a time: in_ready is low from acceptance until the result is taken.
// Reset: asynchronous, active low; counters, occupancy and control registers clear,
// capacity resets to 1024 and best-effort priority to 2; payload registers and slots stay unset.
// Depends on edfq_pkg and edf_deadline_queue_defines.svh.
`include "edf_deadline_queue_defines.svh"
module edf_deadline_queue import edfq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_beat_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:2] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	// One memory of whole slots. Each walk cycle reads slot rd_q and writes the slot that
	// lands at wr_q, so the memory is read and written at one address each per cycle.
	slot_t mem [Entries];

	state_t state_q, state_d;
	in_beat_t req_q;
	logic [10:0] cap_q;
	logic [7:0] be_q;
	logic [CntW-1:0] total_q;
	logic [31:0] sched_q, drop_q;
	logic [CntW-1:0] rd_q;       // next slot index to read
	logic [CntW-1:0] wr_q;       // next slot index to write
	logic [CntW-1:0] cnt_q;      // cancelled count
	logic ins_done_q;            // the new entry has been placed
	slot_t carry_q;              // slot held over while shifting right
	logic carry_v_q;
	slot_t rdata_s1;
	logic rvalid_s1;
	out_beat_t res_q;
	logic [47:0] dl_q;
	logic [1:0] st_q;
	logic [15:0] oh_q;
	logic [3:0] op_q;

	logic accept_in, reject;
	logic [48:0] dl_sum;
	logic [CntW-1:0] cap_eff;
	logic wr_en;
	logic [IdxW-1:0] wr_addr, rd_addr;
	slot_t wr_data, new_slot;
	logic goes_before;
	logic deq_first;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BE_PRIO) ? {24'd0, be_q} : {21'd0, cap_q};
	assign in_ready = (state_q == S_IDLE);
	assign accept_in = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;

	assign dl_sum = {1'b0, in_data.now_us} + {17'd0, in_data.rel_deadline_us};
	assign cap_eff = (cap_q > 11'(Entries)) ? CntW'(Entries) : CntW'(cap_q);
	assign reject = (total_q >= cap_eff)
		|| (!in_data.any_path_feasible && in_data.prio_level >= be_q);

	assign new_slot = '{deadline: dl_q, stream: req_q.stream_key, prio: req_q.prio_level,
		handle: req_q.packet_handle, path: req_q.path_index};

	// The new entry goes in front of the read slot when the slot sorts strictly after it.
	assign goes_before = (rdata_s1.deadline > dl_q)
		|| (rdata_s1.deadline == dl_q && rdata_s1.prio > req_q.prio_level);

	// The dequeued slot is slot zero: it is the first slot to come back from the walk.
	assign deq_first = (state_q == S_SCAN) && func_t'(req_q.func) == FUNC_DEQ
		&& st_q == ST_OK && rvalid_s1 && rd_q == CntW'(1) && wr_q == '0;

	// A rejected, empty or unused-code beat skips the walk and goes straight on to read the head.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept_in) state_d = S_SCAN;
			S_SCAN: if (st_q != ST_OK || (rd_q == total_q && !rvalid_s1 && !carry_v_q
					&& (func_t'(req_q.func) != FUNC_ENQ || ins_done_q)))
					state_d = S_HEAD;
			S_HEAD: if (rvalid_s1) state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Walk datapath: pick the write for this cycle.
	always_comb begin
		wr_en = 1'b0;
		wr_data = rdata_s1;
		wr_addr = wr_q[IdxW-1:0];
		if (state_q == S_SCAN && st_q == ST_OK) begin
			case (func_t'(req_q.func))
				FUNC_ENQ: begin
					if (carry_v_q) begin
						wr_en = 1'b1;
						wr_data = carry_q;
					end else if (rvalid_s1 && !ins_done_q && goes_before) begin
						wr_en = 1'b1;
						wr_data = new_slot;
					end else if (!rvalid_s1 && !ins_done_q && rd_q == total_q) begin
						wr_en = 1'b1;
						wr_data = new_slot;
					end
				end
				FUNC_DEQ: wr_en = rvalid_s1 && !deq_first;
				FUNC_CANCEL: wr_en = rvalid_s1 && rdata_s1.stream != req_q.stream_key;
				default: wr_en = 1'b0;
			endcase
		end
	end

	// Reads run back to back; a carried slot is written one place behind the read, and a
	// write to the slot read at the same edge still returns the old contents.
	logic rd_en;
	assign rd_addr = (state_q == S_SCAN) ? rd_q[IdxW-1:0] : '0;
	assign rd_en = (state_q == S_SCAN && st_q == ST_OK && rd_q < total_q)
		|| (state_q == S_HEAD && !rvalid_s1);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q <= 11'(Entries);
			be_q <= 8'd2;
			total_q <= '0;
			sched_q <= '0;
			drop_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
			ins_done_q <= 1'b0;
			carry_v_q <= 1'b0;
			rvalid_s1 <= 1'b0;
			st_q <= ST_OK;
		end else begin
			state_q <= state_d;
			rvalid_s1 <= rd_en;
			if (psel && penable && pwrite) begin
				if (paddr[2] == REG_CAPACITY) cap_q <= pwdata[10:0];
				else be_q <= pwdata[7:0];
			end
			case (state_q)
				S_IDLE: if (accept_in) begin
					rd_q <= '0;
					wr_q <= '0;
					cnt_q <= '0;
					ins_done_q <= 1'b0;
					carry_v_q <= 1'b0;
					case (func_t'(in_data.func))
						FUNC_ENQ: begin
							st_q <= reject ? ST_REJECT : ST_OK;
							if (reject) drop_q <= drop_q + 32'd1;
						end
						FUNC_DEQ: st_q <= (total_q == '0) ? ST_EMPTY : ST_OK;
						FUNC_CANCEL: st_q <= ST_OK;
						default: st_q <= ST_RSVD;
					endcase
				end
				S_SCAN: begin
					if (st_q == ST_OK) begin
						if (rd_en) rd_q <= rd_q + CntW'(1);
						if (wr_en) wr_q <= wr_q + CntW'(1);
						if (func_t'(req_q.func) == FUNC_ENQ) begin
							if (carry_v_q) begin
								carry_v_q <= rvalid_s1;
								carry_q <= rdata_s1;
							end else if (rvalid_s1 && !ins_done_q && goes_before) begin
								ins_done_q <= 1'b1;
								carry_v_q <= 1'b1;
								carry_q <= rdata_s1;
							end else if (!rvalid_s1 && !ins_done_q && rd_q == total_q) begin
								ins_done_q <= 1'b1;
							end else if (rvalid_s1) begin
								wr_q <= wr_q + CntW'(1);
							end
						end
						if (func_t'(req_q.func) == FUNC_CANCEL && rvalid_s1
								&& rdata_s1.stream == req_q.stream_key)
							cnt_q <= cnt_q + CntW'(1);
					end
					if (state_d == S_HEAD && st_q == ST_OK) begin
						case (func_t'(req_q.func))
							FUNC_ENQ: total_q <= total_q + CntW'(1);
							FUNC_DEQ: begin
								total_q <= total_q - CntW'(1);
								sched_q <= sched_q + 32'd1;
							end
							FUNC_CANCEL: total_q <= total_q - cnt_q;
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers: the request, its deadline, the dequeued slot and the result beat.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			req_q <= in_data;
			dl_q <= dl_sum[48] ? '1 : dl_sum[47:0];
		end
		if (deq_first) begin
			oh_q <= rdata_s1.handle;
			op_q <= rdata_s1.path;
		end
		if (accept_in && func_t'(in_data.func) == FUNC_DEQ) begin
			oh_q <= '0;
			op_q <= '0;
		end
		if (state_q == S_HEAD && rvalid_s1) begin
			res_q.status <= (st_q == ST_RSVD) ? ST_OK : st_q;
			res_q.out_handle <= (func_t'(req_q.func) == FUNC_DEQ && st_q == ST_OK) ? oh_q : '0;
			res_q.out_path <= (func_t'(req_q.func) == FUNC_DEQ && st_q == ST_OK) ? op_q : '0;
			res_q.cancelled_count <= (func_t'(req_q.func) == FUNC_CANCEL) ? 11'(cnt_q) : '0;
			res_q.occupancy <= 11'(total_q);
			res_q.head_valid <= (total_q != '0);
			res_q.head_deadline <= (total_q != '0) ? rdata_s1.deadline : '1;
			res_q.head_handle <= (total_q != '0) ? rdata_s1.handle : '0;
			res_q.scheduled_total <= sched_q;
			res_q.dropped_total <= drop_q;
		end
	end

	`EDFQ_ASSERT_IMP(a_occ_bound, 1'b1, total_q <= CntW'(Entries))
	`EDFQ_ASSERT_IMP(a_ready_out, out_valid, !in_ready)
	`EDFQ_ASSERT_NEXT(a_accept_busy, accept_in, !in_ready)
	`EDFQ_ASSERT_IMP(a_carry_enq, carry_v_q, func_t'(req_q.func) == FUNC_ENQ)
endmodule
